### hw/rtl/dcd_pkg.sv
// Package for the detection candidate decode block: field widths, register
// indexes, reset values, stage structs and the saturation helpers.
// Depends on nothing; every other file of the block imports it.
package dcd_pkg;

	localparam int ANCHOR_W    = 14;
	localparam int COORD_W     = 16;
	localparam int SCORE_W     = 16;
	localparam int CLASS_W     = 8;
	localparam int PAD_W       = 12;
	localparam int SCALE_W     = 24;
	localparam int MAX_CLASSES = 256;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 24;

	// Edge numerator, its product with the inverse scale, and the size product.
	localparam int NUM_W       = 19;
	localparam int PROD_W      = NUM_W + SCALE_W;
	localparam int SIZE_PROD_W = COORD_W + SCALE_W;

	localparam logic [CLASS_W-1:0] CLASS_MAX = CLASS_W'(MAX_CLASSES - 1);

	localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THRESHOLD = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PAD_X           = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PAD_Y           = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RECIP_SCALE     = 4'd3;

	localparam logic [SCORE_W-1:0] THRESHOLD_RESET   = 16'd16384;
	localparam logic [SCALE_W-1:0] RECIP_SCALE_RESET = 24'd65536;

	typedef struct packed {
		logic                 emit;
		logic [CLASS_W-1:0]   class_id;
		logic [SCORE_W-1:0]   score;
	} cand_t;

	typedef struct packed {
		logic [PAD_W-1:0]     pad_x;
		logic [PAD_W-1:0]     pad_y;
		logic [SCALE_W-1:0]   recip_scale;
	} geom_t;

	// Divide by 2^21 rounding toward zero, then clamp to a signed 16-bit pixel value.
	function automatic logic [15:0] sat_edge(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		logic signed [PROD_W-22:0] q;
		r = p + (p[PROD_W-1] ? PROD_W'(2097151) : PROD_W'(0));
		q = r[PROD_W-1:21];
		if (q > $signed((PROD_W-21)'(32767)))
			return 16'h7FFF;
		else if (q < -$signed((PROD_W-21)'(32768)))
			return 16'h8000;
		else
			return q[15:0];
	endfunction

	// Divide by 2^20 and clamp to the unsigned 16-bit range.
	function automatic logic [15:0] sat_size(input logic [SIZE_PROD_W-1:0] p);
		logic [SIZE_PROD_W-21:0] q;
		q = p[SIZE_PROD_W-1:20];
		if (|q[SIZE_PROD_W-21:16])
			return 16'hFFFF;
		else
			return q[15:0];
	endfunction

endpackage

### hw/rtl/dcd_score_track.sv
// Running best-class tracker: keeps the per-anchor maximum score, its class
// and the class counter, and flags a candidate on the anchor's last score.
// Depends on dcd_pkg.
module dcd_score_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_s1,
	input  logic [dcd_pkg::SCORE_W-1:0]   score_s1,
	input  logic                          last_s1,
	input  logic [dcd_pkg::SCORE_W-1:0]   threshold,
	output dcd_pkg::cand_t                cand
);
	import dcd_pkg::*;

	logic [SCORE_W-1:0] max_q;
	logic [CLASS_W-1:0] class_q;
	logic [CLASS_W-1:0] count_q;
	logic               beat;
	logic               take;
	logic [SCORE_W-1:0] eff_max;
	logic [CLASS_W-1:0] eff_class;

	assign beat      = en && valid_s1;
	assign take      = score_s1 > max_q;
	assign eff_max   = take ? score_s1 : max_q;
	assign eff_class = take ? count_q : class_q;

	always_comb begin
		cand.emit     = beat && last_s1 && (eff_max > threshold);
		cand.class_id = eff_class;
		cand.score    = eff_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			class_q <= '0;
			count_q <= '0;
		end else if (beat) begin
			if (last_s1) begin
				max_q   <= '0;
				class_q <= '0;
				count_q <= '0;
			end else begin
				max_q   <= eff_max;
				class_q <= eff_class;
				if (count_q != CLASS_MAX)
					count_q <= count_q + CLASS_W'(1);
			end
		end
	end

	// The end of an anchor always returns the tracker to its cleared state.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		beat && last_s1 |=> max_q == '0 && class_q == '0 && count_q == '0)
		else $error("tracker not cleared after last class");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !last_s1 && count_q != CLASS_MAX |=> count_q == $past(count_q) + CLASS_W'(1))
		else $error("class counter did not advance");

	// The winning class can only be a class that has already been seen.
	a_class_bound: assert property (@(posedge clk) disable iff (!arst_n)
		class_q <= count_q)
		else $error("running class ahead of class counter");

	a_zero_max_class: assert property (@(posedge clk) disable iff (!arst_n)
		max_q == '0 |-> class_q == '0)
		else $error("class recorded without a nonzero score");

endmodule

### hw/rtl/dcd_box_map.sv
// Box mapping pipeline: forms the edge numerators, multiplies by the inverse
// scale, then rounds and saturates into the result register.
// Depends on dcd_pkg.
module dcd_box_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  dcd_pkg::cand_t                cand,
	input  dcd_pkg::geom_t                geom,
	input  logic [dcd_pkg::ANCHOR_W-1:0]  anchor_s1,
	input  logic [dcd_pkg::COORD_W-1:0]   cx_s1,
	input  logic [dcd_pkg::COORD_W-1:0]   cy_s1,
	input  logic [dcd_pkg::COORD_W-1:0]   w_s1,
	input  logic [dcd_pkg::COORD_W-1:0]   h_s1,
	output logic                          valid_q,
	output logic [dcd_pkg::ANCHOR_W-1:0]  anchor_q,
	output logic [dcd_pkg::CLASS_W-1:0]   class_q,
	output logic [dcd_pkg::SCORE_W-1:0]   score_q,
	output logic [15:0]                   left_q,
	output logic [15:0]                   top_q,
	output logic [15:0]                   width_q,
	output logic [15:0]                   height_q
);
	import dcd_pkg::*;

	logic                        valid_s2;
	logic [ANCHOR_W-1:0]         anchor_s2;
	logic [CLASS_W-1:0]          class_s2;
	logic [SCORE_W-1:0]          score_s2;
	logic signed [NUM_W-1:0]     num_x_s2;
	logic signed [NUM_W-1:0]     num_y_s2;
	logic [COORD_W-1:0]          w_s2;
	logic [COORD_W-1:0]          h_s2;

	logic                        valid_s3;
	logic [ANCHOR_W-1:0]         anchor_s3;
	logic [CLASS_W-1:0]          class_s3;
	logic [SCORE_W-1:0]          score_s3;
	logic signed [PROD_W-1:0]    prod_x_s3;
	logic signed [PROD_W-1:0]    prod_y_s3;
	logic [SIZE_PROD_W-1:0]      prod_w_s3;
	logic [SIZE_PROD_W-1:0]      prod_h_s3;

	logic signed [NUM_W-1:0]     num_x;
	logic signed [NUM_W-1:0]     num_y;
	logic signed [SCALE_W:0]     inv_signed;

	// Left edge in Q12.4 doubled: 2*(cx - pad*16) - w, so the half width stays exact.
	assign num_x = $signed({2'b00, cx_s1, 1'b0}) - $signed({2'b00, geom.pad_x, 5'b00000})
		- $signed({3'b000, w_s1});
	assign num_y = $signed({2'b00, cy_s1, 1'b0}) - $signed({2'b00, geom.pad_y, 5'b00000})
		- $signed({3'b000, h_s1});
	assign inv_signed = $signed({1'b0, geom.recip_scale});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s2 <= cand.emit;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			anchor_s2 <= anchor_s1;
			class_s2  <= cand.class_id;
			score_s2  <= cand.score;
			num_x_s2  <= num_x;
			num_y_s2  <= num_y;
			w_s2      <= w_s1;
			h_s2      <= h_s1;

			anchor_s3 <= anchor_s2;
			class_s3  <= class_s2;
			score_s3  <= score_s2;
			prod_x_s3 <= num_x_s2 * inv_signed;
			prod_y_s3 <= num_y_s2 * inv_signed;
			prod_w_s3 <= w_s2 * geom.recip_scale;
			prod_h_s3 <= h_s2 * geom.recip_scale;

			anchor_q  <= anchor_s3;
			class_q   <= class_s3;
			score_q   <= score_s3;
			left_q    <= sat_edge(prod_x_s3);
			top_q     <= sat_edge(prod_y_s3);
			width_q   <= sat_size(prod_w_s3);
			height_q  <= sat_size(prod_h_s3);
		end
	end

endmodule

### hw/rtl/detection_candidate_decode_core.sv
// Top level of the detection candidate decode block: configuration registers,
// input register and pipeline flow control.
// Depends on dcd_pkg, dcd_score_track and dcd_box_map.
//
// Usage: the item channel (item_valid / item_stall) carries one class score per
// transaction together with the anchor's box fields; class_last marks the
// anchor's last class. The result channel (result_valid / result_stall) carries
// one candidate per anchor whose best score exceeds score_threshold, and
// nothing for the other anchors.
// Configuration is written through cfg_valid / cfg_ready / cfg_index / cfg_data;
// the user must write it only while no items are in flight, as the block does
// not enforce this. cfg_ready is always high and unknown indexes are ignored.
// Throughput: one item per cycle while item_stall is low. The edge that accepts
// an item loads the input register; the numerator stage, the multiplier stage
// and the result register follow in that order, and a candidate is valid on
// the result port once its anchor's last item reaches the result register.
// Reset clears the registers to their defaults, empties the pipeline and
// clears the running maximum. When the receiver stalls a valid result, the
// whole pipeline holds and item_stall is raised in the same cycle.
module detection_candidate_decode_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dcd_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [dcd_pkg::ANCHOR_W-1:0]        anchor_index,
	input  logic [dcd_pkg::COORD_W-1:0]         center_x,
	input  logic [dcd_pkg::COORD_W-1:0]         center_y,
	input  logic [dcd_pkg::COORD_W-1:0]         box_w,
	input  logic [dcd_pkg::COORD_W-1:0]         box_h,
	input  logic [dcd_pkg::SCORE_W-1:0]         class_score,
	input  logic                                class_last,

	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [dcd_pkg::ANCHOR_W-1:0]        out_anchor,
	output logic [dcd_pkg::CLASS_W-1:0]         class_id,
	output logic [dcd_pkg::SCORE_W-1:0]         best_score,
	output logic signed [15:0]                  box_left,
	output logic signed [15:0]                  box_top,
	output logic [15:0]                         box_width,
	output logic [15:0]                         box_height
);
	import dcd_pkg::*;

	logic [SCORE_W-1:0]   threshold_q;
	geom_t                geom_q;

	logic                 move;
	logic                 valid_s1;
	logic [ANCHOR_W-1:0]  anchor_s1;
	logic [COORD_W-1:0]   cx_s1;
	logic [COORD_W-1:0]   cy_s1;
	logic [COORD_W-1:0]   w_s1;
	logic [COORD_W-1:0]   h_s1;
	logic [SCORE_W-1:0]   score_s1;
	logic                 last_s1;
	cand_t                cand;
	logic [15:0]          left_raw;
	logic [15:0]          top_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q        <= THRESHOLD_RESET;
			geom_q.pad_x       <= '0;
			geom_q.pad_y       <= '0;
			geom_q.recip_scale <= RECIP_SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCORE_THRESHOLD: threshold_q        <= cfg_data[SCORE_W-1:0];
				REG_PAD_X:           geom_q.pad_x       <= cfg_data[PAD_W-1:0];
				REG_PAD_Y:           geom_q.pad_y       <= cfg_data[PAD_W-1:0];
				REG_RECIP_SCALE:     geom_q.recip_scale <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances as a whole unless a finished result is being held.
	assign move       = !result_valid || !result_stall;
	assign item_stall = !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (move)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (move && item_valid) begin
			anchor_s1 <= anchor_index;
			cx_s1     <= center_x;
			cy_s1     <= center_y;
			w_s1      <= box_w;
			h_s1      <= box_h;
			score_s1  <= class_score;
			last_s1   <= class_last;
		end
	end

	dcd_score_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (move),
		.valid_s1  (valid_s1),
		.score_s1  (score_s1),
		.last_s1   (last_s1),
		.threshold (threshold_q),
		.cand      (cand)
	);

	dcd_box_map u_box (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (move),
		.cand      (cand),
		.geom      (geom_q),
		.anchor_s1 (anchor_s1),
		.cx_s1     (cx_s1),
		.cy_s1     (cy_s1),
		.w_s1      (w_s1),
		.h_s1      (h_s1),
		.valid_q   (result_valid),
		.anchor_q  (out_anchor),
		.class_q   (class_id),
		.score_q   (best_score),
		.left_q    (left_raw),
		.top_q     (top_raw),
		.width_q   (box_width),
		.height_q  (box_height)
	);

	assign box_left = $signed(left_raw);
	assign box_top  = $signed(top_raw);

endmodule

### bench/tb_detection_candidate_decode_core.sv
// Testbench for detection_candidate_decode_core: a directed table, then random
// phases of anchors, checked against a best-class and box-decode predictor.
// Depends on dcd_pkg and the detection_candidate_decode_core RTL.
module tb_detection_candidate_decode_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dcd_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 4'd15;

	localparam int RANDOM_ITEMS   = 1450;
	localparam int PHASE_ITEMS    = 182;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int IDLE_PERCENT   = 38;

	typedef struct packed {
		logic [ANCHOR_W-1:0] anchor;
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [COORD_W-1:0]  w;
		logic [COORD_W-1:0]  h;
		logic [SCORE_W-1:0]  score;
		logic                last;
	} score_item_t;

	typedef struct packed {
		logic [ANCHOR_W-1:0] anchor;
		logic [CLASS_W-1:0]  cls;
		logic [SCORE_W-1:0]  score;
		logic signed [15:0]  left;
		logic signed [15:0]  top;
		logic [15:0]         width;
		logic [15:0]         height;
	} candidate_t;

	typedef struct {
		bit                     is_reg;
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0]  reg_data;
		score_item_t            item;
		bit                     typed;
		bit                     want_hit;
		candidate_t             want;
	} plan_row_t;

	typedef enum {MODE_WIDE, MODE_RISING, MODE_FEW, MODE_ZERO} score_mode_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic [ANCHOR_W-1:0]     anchor_index = '0;
	logic [COORD_W-1:0]      center_x = '0;
	logic [COORD_W-1:0]      center_y = '0;
	logic [COORD_W-1:0]      box_w = '0;
	logic [COORD_W-1:0]      box_h = '0;
	logic [SCORE_W-1:0]      class_score = '0;
	logic                    class_last = 1'b0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [ANCHOR_W-1:0]     out_anchor;
	logic [CLASS_W-1:0]      class_id;
	logic [SCORE_W-1:0]      best_score;
	logic signed [15:0]      box_left;
	logic signed [15:0]      box_top;
	logic [15:0]             box_width;
	logic [15:0]             box_height;

	// Shadow of the configuration registers and of the running best class.
	logic [SCORE_W-1:0] cur_threshold = THRESHOLD_RESET;
	logic [PAD_W-1:0]   cur_pad_x = '0;
	logic [PAD_W-1:0]   cur_pad_y = '0;
	logic [SCALE_W-1:0] cur_recip_scale = RECIP_SCALE_RESET;
	logic [SCORE_W-1:0] best_so_far = '0;
	logic [CLASS_W-1:0] best_class = '0;
	logic [CLASS_W-1:0] class_pos = '0;

	candidate_t  pending_candidates[$];
	plan_row_t   directed_plan[$];
	int          mismatch_count = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	bit          steady = 1'b0;

	detection_candidate_decode_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
	end

	function automatic logic signed [15:0] frame_edge(logic [15:0] centre, logic [PAD_W-1:0] pad,
			logic [15:0] size);
		longint diff;
		longint num;
		longint q;
		diff = longint'(centre) - longint'(pad) * 16;
		num = (2 * diff - longint'(size)) * longint'(cur_recip_scale);
		q = (num < 0) ? -((-num) >>> 21) : (num >>> 21);
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic logic [15:0] frame_size(logic [15:0] size);
		longint p;
		p = (longint'(size) * longint'(cur_recip_scale)) >>> 20;
		return (p > 65535) ? 16'hFFFF : p[15:0];
	endfunction

	// Folds one class score into the running maximum; on the anchor's last
	// class it decides whether a candidate comes out and clears the state.
	function automatic bit track_score(input score_item_t it, output candidate_t c);
		bit hit;
		c = '0;
		if (it.score > best_so_far) begin
			best_so_far = it.score;
			best_class = class_pos;
		end
		if (!it.last) begin
			if (class_pos != CLASS_MAX)
				class_pos = class_pos + 1'b1;
			return 1'b0;
		end
		hit = best_so_far > cur_threshold;
		if (hit) begin
			c.anchor = it.anchor;
			c.cls = best_class;
			c.score = best_so_far;
			c.left = frame_edge(it.cx, cur_pad_x, it.w);
			c.top = frame_edge(it.cy, cur_pad_y, it.h);
			c.width = frame_size(it.w);
			c.height = frame_size(it.h);
		end
		best_so_far = '0;
		best_class = '0;
		class_pos = '0;
		return hit;
	endfunction

	function automatic void shadow_reg_write(logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SCORE_THRESHOLD: cur_threshold = data[SCORE_W-1:0];
			REG_PAD_X:           cur_pad_x = data[PAD_W-1:0];
			REG_PAD_Y:           cur_pad_y = data[PAD_W-1:0];
			REG_RECIP_SCALE:     cur_recip_scale = data[SCALE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic score_item_t make_item(logic [ANCHOR_W-1:0] a, logic [15:0] cx,
			logic [15:0] cy, logic [15:0] w, logic [15:0] h, logic [15:0] s, logic last);
		score_item_t it;
		it.anchor = a;
		it.cx = cx;
		it.cy = cy;
		it.w = w;
		it.h = h;
		it.score = s;
		it.last = last;
		return it;
	endfunction

	function automatic candidate_t make_cand(logic [ANCHOR_W-1:0] a, logic [7:0] cls,
			logic [15:0] s, int l, int t, logic [15:0] w, logic [15:0] h);
		candidate_t c;
		c.anchor = a;
		c.cls = cls;
		c.score = s;
		c.left = 16'(l);
		c.top = 16'(t);
		c.width = w;
		c.height = h;
		return c;
	endfunction

	function automatic void plan_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_index = idx;
		row.reg_data = data;
		directed_plan = {directed_plan, row};
	endfunction

	function automatic void plan_item(score_item_t it, bit typed, bit want_hit, candidate_t want);
		plan_row_t row;
		row = '{default: '0};
		row.item = it;
		row.typed = typed;
		row.want_hit = want_hit;
		row.want = want;
		directed_plan = {directed_plan, row};
	endfunction

	function automatic logic [COORD_W-1:0] coord_val();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [PAD_W-1:0] pick_pad();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return PAD_W'($urandom_range(0, 64));
			default: return PAD_W'($urandom);
		endcase
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Outputs are sampled at the falling edge; they hold until the next rising
	// edge, where the transaction completes if result_stall is low.
	always @(negedge clk) begin
		candidate_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_candidates.size() == 0) begin
				$error("unexpected candidate: anchor %0d class %0d", out_anchor, class_id);
				mismatch_count++;
			end else begin
				want = pending_candidates.pop_front();
				check_field("out_anchor", want.anchor, out_anchor);
				check_field("class_id", want.cls, class_id);
				check_field("best_score", want.score, best_score);
				check_field("box_left", $signed(want.left), $signed(box_left));
				check_field("box_top", $signed(want.top), $signed(box_top));
				check_field("box_width", want.width, box_width);
				check_field("box_height", want.height, box_height);
			end
		end
	end

	// A typed row replaces the predicted outcome with the one written in the table.
	task automatic send_item(score_item_t it, bit typed, bit want_hit, candidate_t want);
		candidate_t c;
		bit hit;
		bit taken;
		hit = track_score(it, c);
		if (typed) begin
			hit = want_hit;
			c = want;
		end
		if (hit)
			pending_candidates = {pending_candidates, c};
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		anchor_index <= it.anchor;
		center_x <= it.cx;
		center_y <= it.cy;
		box_w <= it.w;
		box_h <= it.h;
		class_score <= it.score;
		class_last <= it.last;
		do begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// The caller lowers cfg_valid after the last write of a group.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		shadow_reg_write(idx, data);
	endtask

	// Anchors without a candidate may still be in the pipeline when the
	// queue runs empty, so the task also waits out SETTLE_CYCLES before going on.
	task automatic settle_idle();
		item_valid <= 1'b0;
		while (pending_candidates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          phase;
		int          quota;
		int          n;
		int          r;
		bit          prev_reg;
		bit          fixed_box;
		score_mode_t mode;
		score_item_t it;
		logic [15:0] thr;
		logic [23:0] inv;

		// Defaults: threshold 16384, no padding, unit inverse scale.
		plan_item(make_item(14'd0, 16'h0100, 16'h0200, 16'h0080, 16'h0040, 16'd16385, 1'b1),
			1'b1, 1'b1, make_cand(14'd0, 8'd0, 16'd16385, 12, 30, 16'd8, 16'd4));
		plan_item(make_item(14'd1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'd16384, 1'b1),
			1'b1, 1'b0, '0);
		plan_item(make_item(14'd2, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'd0, 1'b0),
			1'b1, 1'b0, '0);
		plan_item(make_item(14'd2, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'd0, 1'b0),
			1'b1, 1'b0, '0);
		plan_item(make_item(14'd2, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'd0, 1'b1),
			1'b1, 1'b0, '0);
		// A tie keeps the first class; the box comes from the last item only.
		plan_item(make_item(14'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd30000, 1'b0),
			1'b1, 1'b0, '0);
		plan_item(make_item(14'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd30000, 1'b0),
			1'b1, 1'b0, '0);
		plan_item(make_item(14'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd20000, 1'b1),
			1'b1, 1'b1, make_cand(14'd5, 8'd0, 16'd30000, 0, 0, 16'd0, 16'd0));
		plan_item(make_item(14'd9, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd100, 1'b0),
			1'b1, 1'b0, '0);
		plan_item(make_item(14'd9, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd65535, 1'b0),
			1'b1, 1'b0, '0);
		plan_item(make_item(14'd16383, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'd200, 1'b1),
			1'b1, 1'b1, make_cand(14'd16383, 8'd1, 16'd65535, 4095, 4095, 16'd0, 16'd0));
		plan_item(make_item(14'd7, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd40000, 1'b1),
			1'b1, 1'b1, make_cand(14'd7, 8'd0, 16'd40000, -2047, -2047, 16'd4095, 16'd4095));
		plan_item(make_item(14'd8, 16'h0A38, 16'h0451, 16'h1F0F, 16'h0333, 16'd50000, 1'b1),
			1'b0, 1'b0, '0);
		plan_reg(REG_SCORE_THRESHOLD, 24'd0);
		plan_reg(REG_RECIP_SCALE, 24'hFFFFFF);
		plan_item(make_item(14'd10, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'd1, 1'b1),
			1'b1, 1'b1, make_cand(14'd10, 8'd0, 16'd1, 32767, 32767, 16'd0, 16'd0));
		plan_reg(REG_PAD_X, 24'd4095);
		plan_reg(REG_PAD_Y, 24'd4095);
		plan_item(make_item(14'd11, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd1, 1'b1),
			1'b1, 1'b1, make_cand(14'd11, 8'd0, 16'd1, -32768, -32768, 16'hFFFF, 16'hFFFF));
		plan_item(make_item(14'd12, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'd65535, 1'b1),
			1'b0, 1'b0, '0);
		plan_reg(REG_RECIP_SCALE, 24'd0);
		plan_item(make_item(14'd13, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'd65535, 1'b1),
			1'b1, 1'b1, make_cand(14'd13, 8'd0, 16'd65535, 0, 0, 16'd0, 16'd0));
		// Writes to unused indexes must leave the maximum threshold in place.
		plan_reg(REG_SCORE_THRESHOLD, 24'd65535);
		plan_reg(REG_UNUSED_LO, 24'd0);
		plan_reg(REG_UNUSED_HI, 24'd0);
		plan_item(make_item(14'd14, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd65535, 1'b1),
			1'b1, 1'b0, '0);
		plan_reg(REG_SCORE_THRESHOLD, 24'(THRESHOLD_RESET));
		plan_reg(REG_PAD_X, 24'd0);
		plan_reg(REG_PAD_Y, 24'd0);
		plan_reg(REG_RECIP_SCALE, 24'(RECIP_SCALE_RESET));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_reg = 1'b0;
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_reg) begin
				if (!prev_reg)
					settle_idle();
				write_reg(directed_plan[i].reg_index, directed_plan[i].reg_data);
			end else begin
				if (prev_reg)
					cfg_valid <= 1'b0;
				send_item(directed_plan[i].item, directed_plan[i].typed,
					directed_plan[i].want_hit, directed_plan[i].want);
			end
			prev_reg = directed_plan[i].is_reg;
		end
		if (prev_reg)
			cfg_valid <= 1'b0;

		items_sent = 0;
		for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
			settle_idle();
			steady = (phase == 2);
			if (phase == 0)
				thr = 16'($urandom_range(0, 50000));
			else
				case ($urandom_range(5))
					0: thr = '0;
					1: thr = '1;
					default: thr = 16'($urandom_range(0, 50000));
				endcase
			case ($urandom_range(4))
				0: inv = '0;
				1: inv = '1;
				2: inv = RECIP_SCALE_RESET;
				3: inv = 24'($urandom_range(16384, 262144));
				default: inv = 24'($urandom);
			endcase
			write_reg(REG_SCORE_THRESHOLD, {8'($urandom), thr});
			write_reg(REG_PAD_X, {12'($urandom), pick_pad()});
			write_reg(REG_PAD_Y, {12'($urandom), pick_pad()});
			write_reg(REG_RECIP_SCALE, inv);
			if ($urandom_range(1))
				write_reg(CFG_INDEX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
					24'($urandom));
			cfg_valid <= 1'b0;

			quota = items_sent + PHASE_ITEMS;
			while (items_sent < quota) begin
				r = $urandom_range(99);
				if (r < 80)
					n = $urandom_range(1, 4);
				else if (r < 95)
					n = $urandom_range(5, 20);
				else if (r < 99)
					n = $urandom_range(21, 255);
				else
					n = $urandom_range(256, 300);
				r = $urandom_range(99);
				mode = (r < 50) ? MODE_WIDE : (r < 70) ? MODE_RISING :
					(r < 95) ? MODE_FEW : MODE_ZERO;
				// Open with one anchor of 256 to 300 classes, which fills the class counter.
				if (phase == 0 && items_sent + PHASE_ITEMS == quota) begin
					n = $urandom_range(256, 300);
					mode = MODE_RISING;
				end
				fixed_box = $urandom_range(1);
				for (int k = 0; k < n; k++) begin
					if (!fixed_box || k == 0) begin
						it.anchor = ANCHOR_W'($urandom);
						it.cx = coord_val();
						it.cy = coord_val();
						it.w = coord_val();
						it.h = coord_val();
					end
					case (mode)
						MODE_WIDE:   it.score = SCORE_W'($urandom);
						MODE_RISING: it.score = SCORE_W'(((k + 1) * 65535) / n);
						MODE_FEW:
							case ($urandom_range(4))
								0: it.score = '0;
								1: it.score = 16'd1;
								2: it.score = THRESHOLD_RESET;
								3: it.score = 16'd40000;
								default: it.score = '1;
							endcase
						default:     it.score = '0;
					endcase
					it.last = (k == n - 1);
					send_item(it, 1'b0, 1'b0, '0);
					items_sent++;
				end
			end
		end

		settle_idle();
		steady = 1'b0;
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
hw/rtl/dcd_pkg.sv
hw/rtl/dcd_score_track.sv
hw/rtl/dcd_box_map.sv
hw/rtl/detection_candidate_decode_core.sv
bench/tb_detection_candidate_decode_core.sv
